/* hdl/assert_macros.svh */
// assertion macros used by the battery filter rtl
// expects aclk and aresetn in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define BVFLB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("immediate implication failed");

// next-cycle implication, checked out of reset
`define BVFLB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* hdl/bvflb_pkg.sv */
// shared constants and types for the battery voltage filter
// no dependencies
`default_nettype none

package bvflb_pkg;

    // millivolt scaling: mv = sample * 271 / 64
    localparam int unsigned SCALE_MUL   = 271;
    localparam int unsigned SCALE_SHIFT = 6;
    localparam int unsigned MUL_BITS    = 9;

    // field and state widths
    localparam int unsigned MV_BITS   = 15;
    localparam int unsigned ACC_BITS  = 28;
    localparam int unsigned WARM_BITS = 8;
    localparam int unsigned CFG_DATA_BITS  = 15;
    localparam int unsigned CFG_INDEX_BITS = 2;

    localparam logic [MV_BITS-1:0] MV_MAX = 15'h7FFF;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_THRESHOLD  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WARMUP_TICKS   = 2'd2;

    // reset values
    localparam logic [MV_BITS-1:0]   LOW_THRESHOLD_RST  = 15'd10500;
    localparam logic [MV_BITS-1:0]   HIGH_THRESHOLD_RST = 15'd11000;
    localparam logic [WARM_BITS-1:0] WARMUP_TICKS_RST   = 8'd100;

    // configuration seen by the filter stage
    typedef struct packed {
        logic [MV_BITS-1:0]   low_threshold;
        logic [MV_BITS-1:0]   high_threshold;
        logic                 warmup_load;
        logic [WARM_BITS-1:0] warmup_value;
    } cfg_t;

endpackage

`default_nettype wire

/* hdl/bvflb_cfg.sv */
// configuration registers: thresholds and warm-up reload
// depends on bvflb_pkg
`default_nettype none

module bvflb_cfg
    import bvflb_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                           cfg
);

    logic [MV_BITS-1:0] low_thr_reg;
    logic [MV_BITS-1:0] high_thr_reg;
    logic               wr_en;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid;

    // threshold registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_thr_reg  <= LOW_THRESHOLD_RST;
            high_thr_reg <= HIGH_THRESHOLD_RST;
        end else if (wr_en) begin
            case (cfg_index)
                REG_LOW_THRESHOLD:  low_thr_reg  <= cfg_data[MV_BITS-1:0];
                REG_HIGH_THRESHOLD: high_thr_reg <= cfg_data[MV_BITS-1:0];
                default: ;
            endcase
        end
    end

    // warm-up reload travels as a one-cycle strobe with its value
    always_comb begin
        cfg.low_threshold  = low_thr_reg;
        cfg.high_threshold = high_thr_reg;
        cfg.warmup_load    = wr_en && (cfg_index == REG_WARMUP_TICKS);
        cfg.warmup_value   = cfg_data[WARM_BITS-1:0];
    end

endmodule

`default_nettype wire

/* hdl/bvflb_scale.sv */
// input stage: takes a converter sample request and registers its millivolt value
// depends on bvflb_pkg
`default_nettype none

module bvflb_scale
    import bvflb_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 12
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [SAMPLE_BITS-1:0] s_adc_sample,
    output logic                        mv_valid,
    input  wire logic                   mv_ready,
    output logic [MV_BITS-1:0]          mv_value
);

    localparam int unsigned PROD_BITS = SAMPLE_BITS + MUL_BITS;

    logic [PROD_BITS-1:0] prod;
    logic [31:0]          scaled_wide;
    logic [MV_BITS-1:0]   scaled_sat;
    logic                 valid_reg;
    logic [MV_BITS-1:0]   mv_reg;
    logic                 load;

    // constant multiply, truncating shift, saturate to 15 bits
    always_comb begin
        prod        = PROD_BITS'(s_adc_sample) * PROD_BITS'(SCALE_MUL);
        scaled_wide = 32'(prod >> SCALE_SHIFT);
        scaled_sat  = (scaled_wide > 32'(MV_MAX)) ? MV_MAX : scaled_wide[MV_BITS-1:0];
    end

    assign s_ready = !valid_reg || mv_ready;
    assign load    = s_valid && s_ready;

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (load) begin
            mv_reg <= scaled_sat;
        end
    end

    assign mv_valid = valid_reg;
    assign mv_value = mv_reg;

endmodule

`default_nettype wire

/* hdl/bvflb_filter.sv */
// filter stage: warm-up preload, leaky integrator, hysteresis flag, result register
// depends on bvflb_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module bvflb_filter
    import bvflb_pkg::*;
#(
    parameter int unsigned FILTER_SHIFT = 13
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cfg_t               cfg,
    input  wire logic               mv_valid,
    output logic                    mv_ready,
    input  wire logic [MV_BITS-1:0] mv_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [MV_BITS-1:0]      m_filtered_mv,
    output logic                    m_low_battery,
    output logic                    m_warming_up
);

    localparam int unsigned WIDE_BITS = ACC_BITS + MV_BITS;

    logic [WARM_BITS-1:0] count_reg,  count_next;
    logic [MV_BITS-1:0]   fv_reg,     fv_next;
    logic [ACC_BITS-1:0]  acc_reg,    acc_next;
    logic                 flag_reg,   flag_next;
    logic                 m_valid_reg;
    logic [MV_BITS-1:0]   out_mv_reg;
    logic                 out_flag_reg;
    logic                 out_warm_reg;

    logic                 advance;
    logic                 preload;
    logic [WIDE_BITS-1:0] pre_wide;
    logic [ACC_BITS-1:0]  acc_sum;
    logic [ACC_BITS-1:0]  acc_shr;
    logic [WARM_BITS-1:0] count_dec;

    // assertion helpers
    logic                 preload_step;
    logic                 count_step;
    logic [ACC_BITS-1:0]  fv_aligned;

    assign mv_ready = !m_valid_reg || m_ready;
    assign advance  = mv_valid && mv_ready;
    assign preload  = (count_reg != '0);
    assign count_dec = count_reg - WARM_BITS'(1);

    // next state for one request
    always_comb begin
        pre_wide  = WIDE_BITS'(mv_value) << FILTER_SHIFT;
        acc_sum   = acc_reg + ACC_BITS'(mv_value) - ACC_BITS'(fv_reg);
        acc_shr   = acc_sum >> FILTER_SHIFT;
        count_next = count_reg;
        fv_next    = fv_reg;
        acc_next   = acc_reg;
        flag_next  = flag_reg;
        if (preload) begin
            fv_next    = mv_value;
            acc_next   = pre_wide[ACC_BITS-1:0];
            count_next = count_dec;
        end else begin
            acc_next = acc_sum;
            fv_next  = (acc_shr > ACC_BITS'(MV_MAX)) ? MV_MAX : acc_shr[MV_BITS-1:0];
            // clearing wins when both compares hit
            if (fv_next < cfg.low_threshold) begin
                flag_next = 1'b1;
            end
            if (fv_next > cfg.high_threshold) begin
                flag_next = 1'b0;
            end
        end
    end

    // filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= WARMUP_TICKS_RST;
            fv_reg    <= '0;
            acc_reg   <= '0;
            flag_reg  <= 1'b0;
        end else begin
            if (cfg.warmup_load) begin
                count_reg <= cfg.warmup_value;
            end else if (advance) begin
                count_reg <= count_next;
            end
            if (advance) begin
                fv_reg   <= fv_next;
                acc_reg  <= acc_next;
                flag_reg <= flag_next;
            end
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (mv_ready) begin
            m_valid_reg <= mv_valid;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_mv_reg   <= fv_next;
            out_flag_reg <= flag_next;
            out_warm_reg <= preload;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_filtered_mv = out_mv_reg;
    assign m_low_battery = out_flag_reg;
    assign m_warming_up  = out_warm_reg;

    assign preload_step = advance && preload;
    assign count_step   = preload_step && !cfg.warmup_load;
    assign fv_aligned   = ACC_BITS'(WIDE_BITS'(fv_reg) << FILTER_SHIFT);

    // preload leaves the accumulator aligned with the filtered value
    `BVFLB_ASSERT_NEXT(a_preload_acc, preload_step, acc_reg == fv_aligned)
    // preload never moves the low-battery flag
    `BVFLB_ASSERT_NEXT(a_preload_flag, preload_step, flag_reg == $past(flag_reg))
    // each preload request uses up one warm-up tick
    `BVFLB_ASSERT_NEXT(a_preload_count, count_step, count_reg == $past(count_dec))
    // result register mirrors the state it was loaded from
    `BVFLB_ASSERT_NEXT(a_result_state, advance, m_filtered_mv == fv_reg && m_low_battery == flag_reg)

endmodule

`default_nettype wire

/* hdl/battery_voltage_filter_lowbat_top.sv */
// top level of the battery voltage filter with low-battery flag
// depends on bvflb_pkg, bvflb_cfg, bvflb_scale and bvflb_filter
`default_nettype none

// Takes one converter sample per request and returns one result per request:
// the filtered battery voltage in millivolts, the low-battery flag and a
// warm-up marker. A new sample can be accepted every clock cycle while results
// are taken; a sample goes through the scale register, then the result register.
// The first stage registers the scaled sample (constant multiply by 271,
// shift by 6, saturate), the second stage updates the leaky integrator and the
// hysteresis flag and holds the result until it is taken. Configuration writes
// are accepted in every cycle; writing the warm-up register restarts the
// preload count.
module battery_voltage_filter_lowbat_top
    import bvflb_pkg::*;
#(
    parameter int unsigned FILTER_SHIFT = 13,
    parameter int unsigned SAMPLE_BITS  = 12
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [SAMPLE_BITS-1:0]    s_adc_sample,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [MV_BITS-1:0]             m_filtered_mv,
    output logic                           m_low_battery,
    output logic                           m_warming_up
);

    cfg_t               cfg;
    logic               mv_valid;
    logic               mv_ready;
    logic [MV_BITS-1:0] mv_value;

    // configuration registers
    bvflb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sample scaling stage
    bvflb_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_adc_sample (s_adc_sample),
        .mv_valid     (mv_valid),
        .mv_ready     (mv_ready),
        .mv_value     (mv_value)
    );

    // filter and result stage
    bvflb_filter #(
        .FILTER_SHIFT (FILTER_SHIFT)
    ) u_filter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .mv_valid      (mv_valid),
        .mv_ready      (mv_ready),
        .mv_value      (mv_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_filtered_mv (m_filtered_mv),
        .m_low_battery (m_low_battery),
        .m_warming_up  (m_warming_up)
    );

endmodule

`default_nettype wire

/* tb/bvflb_result_checker.sv */
`timescale 1ns / 1ps
// result checker for the battery voltage filter: follows the config and sample requests,
// predicts every result and compares it with what the block returns
// depends on bvflb_pkg
module bvflb_result_checker
    import bvflb_pkg::*;
#(
    parameter int unsigned FILTER_SHIFT = 13,
    parameter int unsigned SAMPLE_BITS  = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [SAMPLE_BITS-1:0]    s_adc_sample,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [MV_BITS-1:0]        m_filtered_mv,
    input  logic                      m_low_battery,
    input  logic                      m_warming_up,
    output int                        mismatches,
    output int                        outstanding,
    output int                        checked,
    output int                        warmup_seen,
    output int                        flag_changes
);

    localparam int unsigned PROD_BITS = SAMPLE_BITS + MUL_BITS;

    typedef struct packed {
        logic [MV_BITS-1:0] filtered_mv;
        logic               low_battery;
        logic               warming_up;
    } tick_result_t;

    // own copy of the registers and the filter state
    logic [MV_BITS-1:0]   low_mv;
    logic [MV_BITS-1:0]   high_mv;
    logic [WARM_BITS-1:0] warmup_reload;
    logic [WARM_BITS-1:0] warmup_left;
    logic [MV_BITS-1:0]   filt_mv;
    logic [ACC_BITS-1:0]  integ;
    logic                 lowbat;

    tick_result_t expected_results[$];
    int errs = 0;
    int n_checked = 0;
    int n_warm = 0;
    int n_flag = 0;

    assign mismatches   = errs;
    assign checked      = n_checked;
    assign warmup_seen  = n_warm;
    assign flag_changes = n_flag;

    // converter counts to millivolts, saturating at the field maximum
    function automatic logic [MV_BITS-1:0] to_millivolts(logic [SAMPLE_BITS-1:0] sample);
        logic [PROD_BITS-1:0] product;
        logic [PROD_BITS-1:0] scaled;
        product = PROD_BITS'(sample) * PROD_BITS'(SCALE_MUL);
        scaled  = product >> SCALE_SHIFT;
        return (scaled > PROD_BITS'(MV_MAX)) ? MV_MAX : scaled[MV_BITS-1:0];
    endfunction

    // one tick of the leaky integrator and the hysteresis flag
    function automatic tick_result_t filter_tick(logic [SAMPLE_BITS-1:0] sample);
        logic [MV_BITS-1:0]  mv;
        logic [ACC_BITS-1:0] shifted;
        logic                was_low;
        tick_result_t        res;
        mv      = to_millivolts(sample);
        was_low = lowbat;
        res.warming_up = (warmup_left != '0);
        if (res.warming_up) begin
            // preload: jump straight to the sample
            filt_mv     = mv;
            integ       = ACC_BITS'(mv) << FILTER_SHIFT;
            warmup_left = warmup_left - 1'b1;
            n_warm++;
        end else begin
            integ   = integ + ACC_BITS'(mv) - ACC_BITS'(filt_mv);
            shifted = integ >> FILTER_SHIFT;
            filt_mv = (shifted > ACC_BITS'(MV_MAX)) ? MV_MAX : shifted[MV_BITS-1:0];
            // clearing is applied last so it wins when the thresholds cross
            if (filt_mv < low_mv) lowbat = 1'b1;
            if (filt_mv > high_mv) lowbat = 1'b0;
        end
        if (lowbat != was_low) n_flag++;
        res.filtered_mv = filt_mv;
        res.low_battery = lowbat;
        return res;
    endfunction

    // field by field comparison against the oldest prediction
    task automatic compare_result(tick_result_t want);
        if (m_filtered_mv !== want.filtered_mv) begin
            $display("%0t filtered_mv mismatch: expected %0d, actual %0d",
                     $time, want.filtered_mv, m_filtered_mv);
            errs++;
        end
        if (m_low_battery !== want.low_battery) begin
            $display("%0t low_battery mismatch: expected %0b, actual %0b",
                     $time, want.low_battery, m_low_battery);
            errs++;
        end
        if (m_warming_up !== want.warming_up) begin
            $display("%0t warming_up mismatch: expected %0b, actual %0b",
                     $time, want.warming_up, m_warming_up);
            errs++;
        end
        n_checked++;
    endtask

    // follow every accepted request on the three channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            low_mv        = LOW_THRESHOLD_RST;
            high_mv       = HIGH_THRESHOLD_RST;
            warmup_reload = WARMUP_TICKS_RST;
            warmup_left   = WARMUP_TICKS_RST;
            filt_mv       = '0;
            integ         = '0;
            lowbat        = 1'b0;
            expected_results.delete();
            outstanding  <= 0;
        end else begin
            // register writes, unknown indexes are ignored
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_LOW_THRESHOLD:  low_mv = cfg_data[MV_BITS-1:0];
                    REG_HIGH_THRESHOLD: high_mv = cfg_data[MV_BITS-1:0];
                    REG_WARMUP_TICKS: begin
                        warmup_reload = cfg_data[WARM_BITS-1:0];
                        warmup_left   = warmup_reload;
                    end
                    default: ;
                endcase
            end
            // results are matched before new samples are queued
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual mv %0d low %0b warm %0b",
                             $time, m_filtered_mv, m_low_battery, m_warming_up);
                    errs++;
                end else begin
                    compare_result(expected_results.pop_front());
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(filter_tick(s_adc_sample));
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

/* tb/tb_battery_voltage_filter_lowbat_top.sv */
`timescale 1ns / 1ps
// testbench top for battery_voltage_filter_lowbat_top: clock, reset, sample and config
// requests, result back-pressure and the verdict; depends on bvflb_pkg and bvflb_result_checker
module tb_battery_voltage_filter_lowbat_top;
    import bvflb_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS     = 1000;
    localparam int DRAIN_LIMIT      = 20000;

    logic                      aclk         = 1'b0;
    logic                      aresetn      = 1'b0;
    logic                      cfg_valid    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;
    logic                      s_valid      = 1'b0;
    logic [11:0]               s_adc_sample = '0;
    logic                      m_ready      = 1'b0;
    logic                      cfg_ready;
    logic                      s_ready;
    logic                      m_valid;
    logic [MV_BITS-1:0]        m_filtered_mv;
    logic                      m_low_battery;
    logic                      m_warming_up;

    int mismatches;
    int outstanding;
    int checked;
    int warmup_seen;
    int flag_changes;

    // idling controls for the sender and the receiver, and run counters
    logic sink_hold   = 1'b0;
    logic sink_steady = 1'b0;
    logic src_steady  = 1'b0;
    int   sink_wait   = 0;
    int   items_sent  = 0;
    int   phases      = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    battery_voltage_filter_lowbat_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_adc_sample  (s_adc_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_filtered_mv (m_filtered_mv),
        .m_low_battery (m_low_battery),
        .m_warming_up  (m_warming_up)
    );

    bvflb_result_checker result_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_adc_sample  (s_adc_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_filtered_mv (m_filtered_mv),
        .m_low_battery (m_low_battery),
        .m_warming_up  (m_warming_up),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .checked       (checked),
        .warmup_seen   (warmup_seen),
        .flag_changes  (flag_changes)
    );

    // mostly no gap, sometimes a few cycles, rarely a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] to_mv_reg(int v);
        if (v < 0) return '0;
        if (v > int'(MV_MAX)) return MV_MAX;
        return CFG_DATA_BITS'(v);
    endfunction

    // one sample request; valid stays up when the next one follows at once
    task automatic send_sample(logic [11:0] sample);
        int gap;
        s_valid      <= 1'b1;
        s_adc_sample <= sample;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        gap = src_steady ? 0 : gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // one register write; only the last of a batch drops valid
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data,
                             bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (last) cfg_valid <= 1'b0;
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
    endtask

    // preload to a level, put the thresholds around it, crossed or at random, then push the filter across them
    task automatic random_phase(bit with_hold);
        int level;
        int mv;
        int warm;
        int len;
        int band;
        int lo;
        int hi;
        int mode;
        logic [11:0] sample;
        drain();
        phases++;
        level = $urandom_range(0, 4095);
        mv    = (level * 271) >> 6;
        warm  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        if ($urandom_range(0, 39) == 0) warm = $urandom_range(100, 255);
        band  = $urandom_range(0, 30);
        case ($urandom_range(0, 5))
            0: begin
                lo = $urandom_range(0, 32767);
                hi = $urandom_range(0, 32767);
            end
            1: begin
                // crossed thresholds
                lo = mv + band + 1;
                hi = mv - band - 1;
            end
            default: begin
                lo = mv + $urandom_range(0, 40) - 20;
                hi = lo + band;
            end
        endcase
        write_reg(REG_LOW_THRESHOLD, to_mv_reg(lo), 1'b0);
        write_reg(REG_HIGH_THRESHOLD, to_mv_reg(hi), 1'b0);
        if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, 15'($urandom), 1'b0);
        write_reg(REG_WARMUP_TICKS, {7'($urandom), 8'(warm)}, 1'b1);
        src_steady  = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
        if (with_hold) sink_hold = 1'b1;
        len  = $urandom_range(20, 60);
        mode = $urandom_range(0, 4);
        for (int i = 0; i < warm + len; i++) begin
            if (i < warm) sample = 12'(level);
            else begin
                case (mode)
                    0: sample = 12'($urandom_range(3500, 4095));
                    1: sample = 12'($urandom_range(0, 600));
                    2: sample = 12'($urandom);
                    default: sample = (i - warm < len / 2) ? 12'($urandom_range(3800, 4095))
                                                           : 12'($urandom_range(0, 300));
                endcase
            end
            send_sample(sample);
        end
    endtask

    // receiver: random stalls, steady stretches and one long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (sink_hold) begin
                m_ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
                sink_hold = 1'b0;
            end else if (sink_steady || sink_wait == 0) begin
                m_ready <= 1'b1;
                if (!sink_steady) sink_wait = gap_len();
            end else begin
                m_ready <= 1'b0;
                sink_wait--;
            end
        end
    end

    // stimulus and verdict
    initial begin
        int start_items;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset configuration: warm-up preloads over the sample extremes
        send_sample(12'hFFF);
        send_sample(12'h000);
        send_sample(12'hAAA);
        send_sample(12'h555);
        send_sample(12'd2480);
        drain();

        // zero warm-up carries on from the last preload, flag gets set
        write_reg(REG_LOW_THRESHOLD, MV_MAX, 1'b0);
        write_reg(REG_HIGH_THRESHOLD, MV_MAX, 1'b0);
        write_reg(REG_WARMUP_TICKS, '0, 1'b1);
        send_sample(12'd2480);
        send_sample(12'hFFF);
        drain();

        // crossed thresholds: clearing wins
        write_reg(REG_HIGH_THRESHOLD, '0, 1'b1);
        send_sample(12'h000);
        send_sample(12'hFFF);
        drain();

        // set again, then widest window holds the flag
        write_reg(REG_HIGH_THRESHOLD, MV_MAX, 1'b1);
        send_sample(12'd100);
        drain();
        write_reg(REG_LOW_THRESHOLD, '0, 1'b1);
        send_sample(12'h000);
        send_sample(12'hFFF);
        drain();

        // unknown index ignored; warm-up data above eight bits dropped
        write_reg(REG_UNUSED, 15'h7FFF, 1'b0);
        write_reg(REG_WARMUP_TICKS, 15'h7F03, 1'b1);
        send_sample(12'hFFF);
        send_sample(12'h000);
        send_sample(12'hFFF);
        send_sample(12'h001);
        drain();

        // longest warm-up, with an unknown write part way through
        write_reg(REG_WARMUP_TICKS, 15'h00FF, 1'b1);
        send_sample(12'h800);
        send_sample(12'h7FF);
        drain();
        write_reg(REG_UNUSED, '0, 1'b1);
        send_sample(12'h123);
        send_sample(12'hEDC);

        // random phases, the first one with a long receiver hold-off
        start_items = items_sent;
        random_phase(1'b1);
        while (items_sent - start_items < RANDOM_ITEMS) random_phase(1'b0);

        drain();
        repeat (4) @(posedge aclk);
        $display("run covered %0d samples in %0d random phases: %0d results checked,",
                 items_sent, phases, checked);
        $display("%0d warm-up ticks and %0d low-battery flag changes", warmup_seen, flag_changes);
        if (outstanding != 0)
            $display("%0t %0d expected results never arrived", $time, outstanding);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
